@@ rtl/core/rmic_pkg.sv @@
package rmic_pkg;

    localparam int DIM_W  = 16;
    localparam int IDX_W  = 48;
    localparam int REM_W  = DIM_W;
    // slice division walks every index bit, column division the rows*cols range
    localparam int NUM_A  = IDX_W;
    localparam int NUM_B  = 2 * DIM_W;
    localparam int NUM_CELLS = NUM_A + NUM_B;

    localparam logic OP_SUB2IDX = 1'b0;
    localparam logic OP_IDX2SUB = 1'b1;

    localparam logic [3:0] ADDR_ROWS   = 4'd0;
    localparam logic [3:0] ADDR_COLS   = 4'd4;
    localparam logic [3:0] ADDR_SLICES = 4'd8;
    localparam logic [3:0] ADDR_MODE   = 4'd12;

    typedef struct packed {
        logic             valid;
        logic             op;
        logic             oob;
        logic [IDX_W-1:0] sidx;
        logic [IDX_W-1:0] num;
        logic [REM_W-1:0] rem;
        logic [DIM_W-1:0] slice;
    } t_cell;

endpackage

@@ rtl/core/rmic_front.sv @@
module rmic_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic                       i_op,
    input  logic [rmic_pkg::DIM_W-1:0] i_row,
    input  logic [rmic_pkg::DIM_W-1:0] i_col,
    input  logic [rmic_pkg::DIM_W-1:0] i_slice,
    input  logic [rmic_pkg::IDX_W-1:0] i_index,
    input  logic [rmic_pkg::DIM_W-1:0] i_rows,
    input  logic [rmic_pkg::DIM_W-1:0] i_cols,
    input  logic [rmic_pkg::DIM_W-1:0] i_slices,
    output rmic_pkg::t_cell            o_cell
);

    logic                         r_v1, r_op1, r_oob1;
    logic [2*rmic_pkg::DIM_W-1:0] r_t1;
    logic [rmic_pkg::DIM_W-1:0]   r_si1;
    logic [rmic_pkg::IDX_W-1:0]   r_lin1;

    logic                         r_v2, r_op2, r_oob2;
    logic [rmic_pkg::IDX_W-1:0]   r_p2;
    logic [rmic_pkg::IDX_W-1:0]   r_lin2;

    rmic_pkg::t_cell              r_c3;

    logic [rmic_pkg::DIM_W-1:0]   n_mul_a;
    logic [rmic_pkg::DIM_W-1:0]   n_add;
    logic [2*rmic_pkg::DIM_W-1:0] n_t1;
    logic [rmic_pkg::IDX_W-1:0]   n_p2;

    always_comb begin
        // row*cols + col for subscripts, rows*cols for the bound of an index
        n_mul_a = (i_op == rmic_pkg::OP_IDX2SUB) ? i_rows : i_row;
        n_add   = (i_op == rmic_pkg::OP_IDX2SUB) ? '0 : i_col;
        n_t1    = n_mul_a * i_cols + {{rmic_pkg::DIM_W{1'b0}}, n_add};
        n_p2    = r_t1 * i_slices
                + {{(rmic_pkg::IDX_W-rmic_pkg::DIM_W){1'b0}},
                   ((r_op1 == rmic_pkg::OP_IDX2SUB) ? {rmic_pkg::DIM_W{1'b0}} : r_si1)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_c3.valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_c3.valid <= r_v2;
        end
        if (i_en) begin
            r_op1  <= i_op;
            r_oob1 <= (i_row >= i_rows) || (i_col >= i_cols) || (i_slice >= i_slices);
            r_t1   <= n_t1;
            r_si1  <= i_slice;
            r_lin1 <= i_index;

            r_op2  <= r_op1;
            r_oob2 <= r_oob1;
            r_p2   <= n_p2;
            r_lin2 <= r_lin1;

            r_c3.op    <= r_op2;
            r_c3.oob   <= (r_op2 == rmic_pkg::OP_IDX2SUB) ? (r_lin2 >= r_p2) : r_oob2;
            r_c3.sidx  <= r_p2;
            r_c3.num   <= r_lin2;
            r_c3.rem   <= '0;
            r_c3.slice <= '0;
        end
    end

    assign o_cell = r_c3;

endmodule

@@ rtl/core/rmic_cell.sv @@
module rmic_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [rmic_pkg::DIM_W-1:0] i_div,
    input  rmic_pkg::t_cell            i_cell,
    output rmic_pkg::t_cell            o_cell
);

    rmic_pkg::t_cell           r_cell;
    logic [rmic_pkg::REM_W:0]  n_sh;
    logic                      n_ge;
    logic [rmic_pkg::REM_W:0]  n_rem;

    // one restoring division step: shift in the next dividend bit, try subtract
    always_comb begin
        n_sh  = {i_cell.rem, i_cell.num[rmic_pkg::IDX_W-1]};
        n_ge  = n_sh >= {1'b0, i_div};
        n_rem = n_ge ? (n_sh - {1'b0, i_div}) : n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
        end
        if (i_en) begin
            r_cell.op    <= i_cell.op;
            r_cell.oob   <= i_cell.oob;
            r_cell.sidx  <= i_cell.sidx;
            r_cell.num   <= {i_cell.num[rmic_pkg::IDX_W-2:0], n_ge};
            r_cell.rem   <= n_rem[rmic_pkg::REM_W-1:0];
            r_cell.slice <= i_cell.slice;
        end
    end

    assign o_cell = r_cell;

endmodule

@@ rtl/core/row_major_index_converter.sv @@
// Pipeline from input transfer to result: 3 setup stages, 80 division cells,
// 1 output register.
// Throughput: one item per cycle; the whole chain holds while the output is stalled.
// The division cells retire one quotient bit each: 48 for slices, 32 for columns.
// Reset (synchronous, active low) empties the pipeline and sets the shape to
// 1 x 1 x 1 in 2D mode.
module row_major_index_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // row_in[15:0], col_in[15:0], slice_in[15:0], index_in[47:0]
    input  logic         i_s_tuser,   // operation
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,   // index_out[47:0], row_out, col_out, slice_out
    output logic         o_m_tuser,   // out_of_bounds
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    localparam int DW = rmic_pkg::DIM_W;
    localparam int IW = rmic_pkg::IDX_W;

    logic [DW-1:0] r_rows, r_cols, r_slices;
    logic          r_mode;
    logic [DW-1:0] n_slc;
    logic          n_en;

    rmic_pkg::t_cell w_cell [rmic_pkg::NUM_CELLS+1];
    rmic_pkg::t_cell n_mid;

    logic          r_ov, r_oob;
    logic [95:0]   r_data;
    rmic_pkg::t_cell w_last;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= DW'(1);
            r_cols   <= DW'(1);
            r_slices <= DW'(1);
            r_mode   <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (i_paddr)
                rmic_pkg::ADDR_ROWS:   r_rows   <= i_pwdata[DW-1:0];
                rmic_pkg::ADDR_COLS:   r_cols   <= i_pwdata[DW-1:0];
                rmic_pkg::ADDR_SLICES: r_slices <= i_pwdata[DW-1:0];
                rmic_pkg::ADDR_MODE:   r_mode   <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr)
            rmic_pkg::ADDR_ROWS:   o_prdata = {{(32-DW){1'b0}}, r_rows};
            rmic_pkg::ADDR_COLS:   o_prdata = {{(32-DW){1'b0}}, r_cols};
            rmic_pkg::ADDR_SLICES: o_prdata = {{(32-DW){1'b0}}, r_slices};
            rmic_pkg::ADDR_MODE:   o_prdata = {31'b0, r_mode};
            default:               o_prdata = '0;
        endcase
    end

    assign n_slc      = r_mode ? r_slices : DW'(1);
    assign n_en       = !r_ov || i_m_tready;
    assign o_s_tready = n_en;

    rmic_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (n_en),
        .i_valid  (i_s_tvalid),
        .i_op     (i_s_tuser),
        .i_row    (i_s_tdata[15:0]),
        .i_col    (i_s_tdata[31:16]),
        .i_slice  (i_s_tdata[47:32]),
        .i_index  (i_s_tdata[95:48]),
        .i_rows   (r_rows),
        .i_cols   (r_cols),
        .i_slices (n_slc),
        .o_cell   (w_cell[0])
    );

    // after the slice division: keep the slice, restart on the quotient by columns
    always_comb begin
        n_mid       = w_cell[rmic_pkg::NUM_A];
        n_mid.slice = w_cell[rmic_pkg::NUM_A].rem;
        n_mid.rem   = '0;
        n_mid.num   = {w_cell[rmic_pkg::NUM_A].num[rmic_pkg::NUM_B-1:0],
                       {(IW-rmic_pkg::NUM_B){1'b0}}};
    end

    for (genvar k = 0; k < rmic_pkg::NUM_CELLS; k++) begin : g_cell
        rmic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_div   ((k < rmic_pkg::NUM_A) ? n_slc : r_cols),
            .i_cell  ((k == rmic_pkg::NUM_A) ? n_mid : w_cell[k]),
            .o_cell  (w_cell[k+1])
        );
    end

    assign w_last = w_cell[rmic_pkg::NUM_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (n_en) begin
            r_ov <= w_last.valid;
        end
        if (n_en) begin
            r_oob <= w_last.oob;
            if (w_last.oob) begin
                r_data <= '0;
            end else if (w_last.op == rmic_pkg::OP_SUB2IDX) begin
                r_data <= {48'b0, w_last.sidx};
            end else begin
                r_data <= {w_last.slice, w_last.rem, w_last.num[DW-1:0], 48'b0};
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_oob;

endmodule
